>>> rtl/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

    // Field widths
    localparam int ADDR_W        = 31;
    localparam int PSIZE_W       = 21;
    localparam int FIU_W         = 5;
    localparam int FRAME_OUT_W   = 4;
    localparam int TOTAL_W       = 32;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 21;

    // Defaults and reset values
    localparam int MAX_FRAMES_DEF = 16;
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = PSIZE_W'(4096);
    localparam logic [FIU_W-1:0]   FRAMES_RST    = FIU_W'(16);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = CFG_IDX_W'(1);

    // Divider steps, one quotient bit each
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Command broadcast to every frame cell
    typedef struct packed {
        logic              flush;
        logic              upd;
        logic              age_all;
        logic [ADDR_W-1:0] page;
    } t_cell_cmd;

    // Status of one frame cell
    typedef struct packed {
        logic valid;
        logic hit;
        logic empty;
        logic lru;
    } t_cell_stat;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_UPD  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

>>> rtl/lrupr_if.sv
`default_nettype none

interface lrupr_req_if
    import lrupr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] ref_address;

    modport source (output valid, output ref_address, input ready);
    modport sink   (input valid, input ref_address, output ready);
endinterface

interface lrupr_rsp_if
    import lrupr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   fault;
    logic [FRAME_OUT_W-1:0] frame_used;
    logic [ADDR_W-1:0]      page_number;
    logic [TOTAL_W-1:0]     fault_total;

    modport source (output valid, output fault, output frame_used, output page_number,
                    output fault_total, input ready);
    modport sink   (input valid, input fault, input frame_used, input page_number,
                    input fault_total, output ready);
endinterface

interface lrupr_cfg_if
    import lrupr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lrupr_div.sv
`default_nettype none

module lrupr_div
    import lrupr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [ADDR_W-1:0]  i_dividend,
    input  wire logic [PSIZE_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [ADDR_W-1:0]       o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_q;
    logic [PSIZE_W-1:0]   r_rem;
    logic [PSIZE_W-1:0]   r_div;

    logic [PSIZE_W:0]     w_trial;
    logic                 w_ge;
    logic [PSIZE_W:0]     w_diff;

    // Shift in the next dividend bit and try to subtract
    always_comb begin
        w_trial = {r_rem, r_q[ADDR_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    // Control: count the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[ADDR_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PSIZE_W-1:0] : w_trial[PSIZE_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

>>> rtl/lrupr_cell.sv
`default_nettype none

module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int RANK_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic              i_sel,
    input  wire logic              i_active,
    input  wire logic              i_prev_valid,
    input  wire logic [RANK_W-1:0] i_old_rank,
    input  wire logic [RANK_W-1:0] i_lru_rank,
    output t_cell_stat             o_stat,
    output logic [RANK_W-1:0]      o_rank
);

    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic [ADDR_W-1:0] r_page;
    logic              w_age;

    // Local lookup results
    always_comb begin
        o_stat.valid = r_valid;
        o_stat.hit   = i_active && r_valid && (r_page == i_cmd.page);
        o_stat.empty = i_active && !r_valid && i_prev_valid;
        o_stat.lru   = i_active && r_valid && (r_rank == i_lru_rank);
        w_age        = i_active && r_valid && !i_sel
                       && (i_cmd.age_all || (r_rank < i_old_rank));
    end

    // Valid and recency rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.flush) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.upd) begin
            if (i_sel) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (w_age) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    // Page tag, loaded when this frame takes the page
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && i_sel) begin
            r_page <= i_cmd.page;
        end
    end

    assign o_rank = r_rank;

endmodule

`default_nettype wire

>>> rtl/lru_page_replacement_top.sv
`default_nettype none

// Fully associative LRU page replacement. Each request carries a reference
// address; the block divides it by page_size (zero reads as one) to get a page
// number, looks it up in a row of frame cells, refreshes recency on a hit, and
// on a miss fills the lowest empty active frame or evicts the least recently
// used one, counting the fault (saturating). One request is worked at a time
// and passes from acceptance to result through the bit-serial divider, the
// divider's done flag, the lookup across the cells and the cell update. The
// next request can be accepted the cycle after the result is loaded; a stalled
// result holds the block in its update step until the output register frees up.
// The next request is taken while a result still waits in the output register.
// Writing frames_in_use flushes all frames; the fault total is kept. Write
// configuration only while no request is in flight.
module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lrupr_cfg_if.sink  i_cfg,
    lrupr_req_if.sink  i_req,
    lrupr_rsp_if.source o_rsp
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    t_state               r_state;
    logic [PSIZE_W-1:0]   r_page_size;
    logic [FIU_W-1:0]     r_frames;
    logic [TOTAL_W-1:0]   r_fault_cnt;
    logic [TOTAL_W-1:0]   n_fault_cnt;

    logic [MAX_FRAMES-1:0] r_sel;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_hit;
    logic                  r_age_all;
    logic [IDX_W-1:0]      r_old_rank;

    logic                   r_out_valid;
    logic                   r_out_fault;
    logic [FRAME_OUT_W-1:0] r_out_frame;
    logic [ADDR_W-1:0]      r_out_page;
    logic [TOTAL_W-1:0]     r_out_total;

    logic                  w_req_acc;
    logic                  w_cfg_acc;
    logic                  w_slot_free;
    logic [PSIZE_W-1:0]    w_divisor;
    logic                  w_div_done;
    logic [ADDR_W-1:0]     w_quot;
    logic [CNT_W-1:0]      w_n;
    logic [IDX_W-1:0]      w_lru_rank;
    t_cell_cmd             w_cmd;

    t_cell_stat            w_stat [MAX_FRAMES];
    logic [IDX_W-1:0]      w_rank [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] w_active;
    logic [MAX_FRAMES-1:0] w_prev_valid;
    logic [MAX_FRAMES-1:0] w_hit_vec;
    logic [MAX_FRAMES-1:0] w_empty_vec;
    logic [MAX_FRAMES-1:0] w_lru_vec;
    logic [MAX_FRAMES-1:0] w_sel;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_old_rank;

    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PAGE_SIZE_RST;
            r_frames    <= FRAMES_RST;
        end else if (w_cfg_acc) begin
            if (i_cfg.index == REG_PAGE_SIZE) begin
                r_page_size <= i_cfg.data[PSIZE_W-1:0];
            end else if (i_cfg.index == REG_FRAMES_IN_USE) begin
                r_frames <= i_cfg.data[FIU_W-1:0];
            end
        end
    end

    // Active frame count and the rank the LRU frame holds
    always_comb begin
        if (r_frames == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_frames) > 32'(MAX_FRAMES)) begin
            w_n = CNT_W'(MAX_FRAMES);
        end else begin
            w_n = CNT_W'(r_frames);
        end
        w_lru_rank = IDX_W'(w_n - CNT_W'(1));
        w_divisor  = (r_page_size == '0) ? PSIZE_W'(1) : r_page_size;
    end

    lrupr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_req_acc),
        .i_dividend (i_req.ref_address),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Broadcast command to the cells
    always_comb begin
        w_cmd.flush   = w_cfg_acc && (i_cfg.index == REG_FRAMES_IN_USE);
        w_cmd.upd     = (r_state == ST_UPD) && w_slot_free;
        w_cmd.age_all = r_age_all;
        w_cmd.page    = w_quot;
    end

    // Row of frame cells; each sees its left neighbor's valid bit
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        assign w_active[g] = 32'(g) < 32'(w_n);
        if (g == 0) begin : g_first
            assign w_prev_valid[g] = 1'b1;
        end else begin : g_rest
            assign w_prev_valid[g] = w_stat[g-1].valid;
        end
        assign w_hit_vec[g]   = w_stat[g].hit;
        assign w_empty_vec[g] = w_stat[g].empty;
        assign w_lru_vec[g]   = w_stat[g].lru;

        lrupr_cell #(
            .RANK_W (IDX_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_sel        (r_sel[g]),
            .i_active     (w_active[g]),
            .i_prev_valid (w_prev_valid[g]),
            .i_old_rank   (r_old_rank),
            .i_lru_rank   (w_lru_rank),
            .o_stat       (w_stat[g]),
            .o_rank       (w_rank[g])
        );
    end

    // Pick the frame: hit, else first empty, else LRU; encode the one-hot pick
    always_comb begin
        if (|w_hit_vec) begin
            w_sel = w_hit_vec;
        end else if (|w_empty_vec) begin
            w_sel = w_empty_vec;
        end else begin
            w_sel = w_lru_vec;
        end
        w_idx      = '0;
        w_old_rank = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_idx      = w_idx | (w_sel[i] ? IDX_W'(i) : '0);
            w_old_rank = w_old_rank | (w_sel[i] ? w_rank[i] : '0);
        end
    end

    // Hold the lookup outcome for the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            r_sel      <= w_sel;
            r_idx      <= w_idx;
            r_hit      <= |w_hit_vec;
            r_age_all  <= !(|w_hit_vec) && (|w_empty_vec);
            r_old_rank <= w_old_rank;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_req_acc) r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) r_state <= ST_LOOK;
                end
                ST_LOOK: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (w_slot_free) r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Saturating fault counter
    always_comb begin
        n_fault_cnt = r_fault_cnt;
        if (!r_hit && (r_fault_cnt != '1)) begin
            n_fault_cnt = r_fault_cnt + TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_cnt <= '0;
        end else if (w_cmd.upd) begin
            r_fault_cnt <= n_fault_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.upd) begin
            r_out_fault <= !r_hit;
            r_out_frame <= FRAME_OUT_W'(r_idx);
            r_out_page  <= w_quot;
            r_out_total <= n_fault_cnt;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.fault       = r_out_fault;
    assign o_rsp.frame_used  = r_out_frame;
    assign o_rsp.page_number = r_out_page;
    assign o_rsp.fault_total = r_out_total;

endmodule

`default_nettype wire

>>> rtl/lrupr_chk.sv
`default_nettype none

module lrupr_chk
    import lrupr_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_req_valid,
    input wire logic               i_req_ready,
    input wire logic               i_rsp_valid,
    input wire logic               i_rsp_ready,
    input wire logic [ADDR_W-1:0]  i_rsp_page,
    input wire logic [TOTAL_W-1:0] i_rsp_total
);

    // A stalled response stays
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_page) && $stable(i_rsp_total))
        else $error("response payload changed while stalled");

    // Any response follows at least one fault, so the total is never zero
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_total != '0)
        else $error("response with zero fault total");

    // Block is busy right after taking a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

endmodule

bind lru_page_replacement_top lrupr_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_page  (o_rsp.page_number),
    .i_rsp_total (o_rsp.fault_total)
);

`default_nettype wire
